FILE: rtl/sbs_pkg.sv
// shared types and constants for the sphere brush signed distance block
// no dependencies

package sbs_pkg;

  localparam int RadW  = 23;
  localparam int VsW   = 16;
  localparam int StrW  = 16;
  localparam int SdfW  = 20;
  localparam int SumW  = 63;   // saturated squared distance, at most 2^62
  localparam int RootW = 32;   // floor square root of SumW bits
  localparam int BndW  = 25;   // radius + falloff + 2.0
  localparam int CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CENTER_X   = 3'd0,
    REG_CENTER_Y   = 3'd1,
    REG_CENTER_Z   = 3'd2,
    REG_RADIUS     = 3'd3,
    REG_FALLOFF    = 3'd4,
    REG_VOXEL_SIZE = 3'd5,
    REG_STRENGTH   = 3'd6,
    REG_DIG_MODE   = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic within_bounds;
    logic within_interior;
  } flags_t;

endpackage

FILE: rtl/sbs_sqdist.sv
// squared distance stages: per-axis square, then saturating sum
// depends on sbs_pkg

module sbs_sqdist import sbs_pkg::*; #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic signed [COORD_WIDTH-1:0] px_i,
  input  logic signed [COORD_WIDTH-1:0] py_i,
  input  logic signed [COORD_WIDTH-1:0] pz_i,
  input  logic signed [COORD_WIDTH-1:0] cx_i,
  input  logic signed [COORD_WIDTH-1:0] cy_i,
  input  logic signed [COORD_WIDTH-1:0] cz_i,
  output logic                          valid_o,
  output logic [SumW-1:0]               sum_o
);

  localparam logic [SumW-1:0] SqCap = SumW'(1) << (SumW - 1);

  logic [SumW-1:0] sq_d [3];
  logic [SumW-1:0] sq_q [3];
  logic            v1_q;
  logic [SumW-1:0] sum_q;
  logic            v2_q;
  logic [SumW+1:0] tot;

  function automatic logic [SumW-1:0] sq_axis(logic signed [COORD_WIDTH-1:0] p,
                                               logic signed [COORD_WIDTH-1:0] c);
    logic signed [COORD_WIDTH:0] d;
    logic [COORD_WIDTH:0]        m;
    logic [32:0]                 m33;
    logic [30:0]                 mm;
    d   = (COORD_WIDTH+1)'(p) - (COORD_WIDTH+1)'(c);
    m   = d[COORD_WIDTH] ? (COORD_WIDTH+1)'(-d) : (COORD_WIDTH+1)'(d);
    m33 = 33'(m);
    mm  = m33[30:0];
    if (|m33[32:31]) begin
      return SqCap;
    end
    return SumW'({31'd0, mm} * {31'd0, mm});
  endfunction

  always_comb begin
    sq_d[0] = sq_axis(px_i, cx_i);
    sq_d[1] = sq_axis(py_i, cy_i);
    sq_d[2] = sq_axis(pz_i, cz_i);
  end

  assign tot = (SumW+2)'(sq_q[0]) + (SumW+2)'(sq_q[1]) + (SumW+2)'(sq_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q  <= sq_d;
      sum_q <= (tot > (SumW+2)'(SqCap)) ? SqCap : tot[SumW-1:0];
    end
  end

  assign valid_o = v2_q;
  assign sum_o   = sum_q;

endmodule

FILE: rtl/sbs_isqrt.sv
// pipelined floor square root, one result bit per stage
// depends on sbs_pkg

module sbs_isqrt import sbs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [SumW-1:0]  sum_i,
  input  flags_t           flags_i,
  output logic             valid_o,
  output logic [RootW-1:0] root_o,
  output flags_t           flags_o
);

  logic [SumW:0]    rem_w  [RootW+1];
  logic [RootW-1:0] root_w [RootW+1];
  flags_t           flg_w  [RootW+1];
  logic             vld_w  [RootW+1];

  assign rem_w[0]  = (SumW+1)'(sum_i);
  assign root_w[0] = '0;
  assign flg_w[0]  = flags_i;
  assign vld_w[0]  = valid_i;

  for (genvar k = 0; k < RootW; k++) begin : g_stage
    localparam int Bit = RootW - 1 - k;
    logic [SumW:0]    trial;
    logic             ge;
    logic [SumW:0]    rem_q;
    logic [RootW-1:0] root_q;
    flags_t           flg_q;
    logic             vld_q;

    assign trial = ((SumW+1)'(root_w[k]) << (Bit + 1)) | ((SumW+1)'(1) << (2 * Bit));
    assign ge    = rem_w[k] >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en_i) begin
        vld_q <= vld_w[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q  <= ge ? rem_w[k] - trial : rem_w[k];
        root_q <= ge ? (root_w[k] | (RootW'(1) << Bit)) : root_w[k];
        flg_q  <= flg_w[k];
      end
    end

    assign rem_w[k+1]  = rem_q;
    assign root_w[k+1] = root_q;
    assign flg_w[k+1]  = flg_q;
    assign vld_w[k+1]  = vld_q;
  end

  assign valid_o = vld_w[RootW];
  assign root_o  = root_w[RootW];
  assign flags_o = flg_w[RootW];

endmodule

FILE: rtl/sbs_div.sv
// (radius - distance) / voxel size: setup stage, one quotient bit per stage,
// clamp stage; depends on sbs_pkg

module sbs_div import sbs_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [RootW-1:0]     dist_i,
  input  logic [RadW-1:0]      radius_i,
  input  logic [VsW-1:0]       voxel_size_i,
  input  flags_t               flags_i,
  output logic                 valid_o,
  output logic [FRAC_BITS+2:0] mag_o,
  output logic                 neg_o,
  output flags_t               flags_o
);

  localparam int QW   = FRAC_BITS + 3;
  localparam int NW   = RootW + FRAC_BITS;
  localparam int DW   = VsW + QW;
  localparam logic [QW-1:0] Lim = QW'(5) << FRAC_BITS;

  // setup stage
  logic [RootW-1:0] diff;
  logic             neg_d;
  logic [NW-1:0]    num;
  logic [VsW-1:0]   vsn;
  logic             sat_d;

  assign neg_d = dist_i > RootW'(radius_i);
  assign diff  = neg_d ? dist_i - RootW'(radius_i) : RootW'(radius_i) - dist_i;
  assign num   = NW'(diff) << FRAC_BITS;
  assign vsn   = (voxel_size_i == '0) ? VsW'(1) : voxel_size_i;
  assign sat_d = num >= NW'(DW'(vsn) << QW);

  logic [NW-1:0]  rem_w [QW+1];
  logic [QW-1:0]  quo_w [QW+1];
  logic [VsW-1:0] vs_w  [QW+1];
  logic           neg_w [QW+1];
  logic           sat_w [QW+1];
  flags_t         flg_w [QW+1];
  logic           vld_w [QW+1];

  logic [NW-1:0]  rem0_q;
  logic [VsW-1:0] vs0_q;
  logic           neg0_q, sat0_q, vld0_q;
  flags_t         flg0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
    end else if (en_i) begin
      vld0_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem0_q <= num;
      vs0_q  <= vsn;
      neg0_q <= neg_d;
      sat0_q <= sat_d;
      flg0_q <= flags_i;
    end
  end

  assign rem_w[0] = rem0_q;
  assign quo_w[0] = '0;
  assign vs_w[0]  = vs0_q;
  assign neg_w[0] = neg0_q;
  assign sat_w[0] = sat0_q;
  assign flg_w[0] = flg0_q;
  assign vld_w[0] = vld0_q;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int Bit = QW - 1 - k;
    logic [NW-1:0]  sub;
    logic           ge;
    logic [NW-1:0]  rem_q;
    logic [QW-1:0]  quo_q;
    logic [VsW-1:0] vs_q;
    logic           neg_q, sat_q, vld_q;
    flags_t         flg_q;

    assign sub = NW'(vs_w[k]) << Bit;
    assign ge  = rem_w[k] >= sub;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en_i) begin
        vld_q <= vld_w[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q <= ge ? rem_w[k] - sub : rem_w[k];
        quo_q <= ge ? (quo_w[k] | (QW'(1) << Bit)) : quo_w[k];
        vs_q  <= vs_w[k];
        neg_q <= neg_w[k];
        sat_q <= sat_w[k];
        flg_q <= flg_w[k];
      end
    end

    assign rem_w[k+1] = rem_q;
    assign quo_w[k+1] = quo_q;
    assign vs_w[k+1]  = vs_q;
    assign neg_w[k+1] = neg_q;
    assign sat_w[k+1] = sat_q;
    assign flg_w[k+1] = flg_q;
    assign vld_w[k+1] = vld_q;
  end

  // clamp stage
  logic [QW-1:0] mag_q;
  logic          neg_q, vld_q;
  flags_t        flg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_w[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q <= (sat_w[QW] || (quo_w[QW] > Lim)) ? Lim : quo_w[QW];
      neg_q <= neg_w[QW];
      flg_q <= flg_w[QW];
    end
  end

  assign valid_o = vld_q;
  assign mag_o   = mag_q;
  assign neg_o   = neg_q;
  assign flags_o = flg_q;

endmodule

FILE: rtl/sphere_brush_sdf.sv
// top level of the sphere brush signed distance block: config registers,
// bounds tests, strength scaling and output; uses sbs_pkg, sbs_sqdist,
// sbs_isqrt and sbs_div
//
//   channel  | direction | handshake              | contents
//   ---------+-----------+------------------------+---------------------------------
//   s_axis   | in        | tvalid/tready          | point_x, point_y, point_z
//   m_axis   | out       | tvalid/tready          | sdf, within_bounds, within_interior
//   cfg      | in        | cfg_we_i, no back-press| register index, write data
//
// one point enters per cycle unless m_axis stalls; latency is dominated by the
// bit-per-stage square root and the bit-per-stage quotient
// reset clears all valid bits and loads the register defaults
// a stall on m_axis freezes the whole pipeline at once; s_axis_tready falls
// only while the output holds a result that is not taken

module sphere_brush_sdf import sbs_pkg::*; #(
  parameter int COORD_WIDTH = 24,
  parameter int FRAC_BITS   = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  // point_x, point_y, point_z from the lowest bit up, zero padded to bytes
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
  // sdf, within_bounds, within_interior from the lowest bit up, zero padded
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [((SdfW+2+7)/8)*8-1:0]           m_axis_tdata,
  // configuration writes
  input  logic                                  cfg_we_i,
  input  logic [CfgIdxW-1:0]                    cfg_idx_i,
  input  logic [((COORD_WIDTH > RadW) ? COORD_WIDTH : RadW)-1:0] cfg_data_i
);

  localparam int OutW = ((SdfW + 2 + 7) / 8) * 8;
  localparam int QW   = FRAC_BITS + 3;
  localparam int PW   = QW + StrW;

  // config registers
  logic signed [COORD_WIDTH-1:0] cx_q, cy_q, cz_q;
  logic [RadW-1:0]               radius_q, falloff_q;
  logic [VsW-1:0]                vs_q;
  logic [StrW-1:0]               str_q;
  logic                          dig_q;
  // derived bounds, refreshed from the registers every cycle
  logic [BndW-1:0]               rb_q;
  logic [2*BndW-1:0]             rbsq_q;
  logic [2*RadW-1:0]             rsq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q      <= '0;
      cy_q      <= '0;
      cz_q      <= '0;
      radius_q  <= '0;
      falloff_q <= '0;
      vs_q      <= VsW'(1) << FRAC_BITS;
      str_q     <= StrW'(1) << FRAC_BITS;
      dig_q     <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_CENTER_X:   cx_q      <= cfg_data_i[COORD_WIDTH-1:0];
        REG_CENTER_Y:   cy_q      <= cfg_data_i[COORD_WIDTH-1:0];
        REG_CENTER_Z:   cz_q      <= cfg_data_i[COORD_WIDTH-1:0];
        REG_RADIUS:     radius_q  <= cfg_data_i[RadW-1:0];
        REG_FALLOFF:    falloff_q <= cfg_data_i[RadW-1:0];
        REG_VOXEL_SIZE: vs_q      <= cfg_data_i[VsW-1:0];
        REG_STRENGTH:   str_q     <= cfg_data_i[StrW-1:0];
        REG_DIG_MODE:   dig_q     <= cfg_data_i[0];
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    rb_q   <= BndW'(radius_q) + BndW'(falloff_q) + (BndW'(2) << FRAC_BITS);
    rbsq_q <= (2*BndW)'(rb_q) * (2*BndW)'(rb_q);
    rsq_q  <= (2*RadW)'(radius_q) * (2*RadW)'(radius_q);
  end

  // whole pipeline moves unless a finished result is held and not taken
  logic en;
  logic vout_q;
  assign en            = !vout_q || m_axis_tready;
  assign s_axis_tready = en;

  // stages 1-2: squared distance
  logic            sum_v;
  logic [SumW-1:0] sum;

  sbs_sqdist #(.COORD_WIDTH(COORD_WIDTH)) u_sqdist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .px_i    (s_axis_tdata[COORD_WIDTH-1:0]),
    .py_i    (s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
    .pz_i    (s_axis_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH]),
    .cx_i    (cx_q),
    .cy_i    (cy_q),
    .cz_i    (cz_q),
    .valid_o (sum_v),
    .sum_o   (sum)
  );

  // stage 3: sphere tests
  logic            v3_q;
  logic [SumW-1:0] sum3_q;
  flags_t          flg3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= sum_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sum3_q                 <= sum;
      flg3_q.within_bounds   <= sum <= SumW'(rbsq_q);
      flg3_q.within_interior <= sum <= SumW'(rsq_q);
    end
  end

  // square root
  logic             rt_v;
  logic [RootW-1:0] root_dist;
  flags_t           rt_flg;

  sbs_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3_q),
    .sum_i   (sum3_q),
    .flags_i (flg3_q),
    .valid_o (rt_v),
    .root_o  (root_dist),
    .flags_o (rt_flg)
  );

  // divide by voxel size and clamp to 5.0
  logic          dv_v;
  logic [QW-1:0] mag;
  logic          dv_neg;
  flags_t        dv_flg;

  sbs_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (rt_v),
    .dist_i       (root_dist),
    .radius_i     (radius_q),
    .voxel_size_i (vs_q),
    .flags_i      (rt_flg),
    .valid_o      (dv_v),
    .mag_o        (mag),
    .neg_o        (dv_neg),
    .flags_o      (dv_flg)
  );

  // strength product; fill mode flips the sign
  logic          vm_q;
  logic [PW-1:0] prod_q;
  logic          negm_q;
  flags_t        flgm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q <= 1'b0;
    end else if (en) begin
      vm_q <= dv_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q <= PW'(mag) * PW'(str_q);
      negm_q <= dv_neg ^ !dig_q;
      flgm_q <= dv_flg;
    end
  end

  // output register: truncate the product, apply the sign
  logic [PW-1:0]   scaled;
  logic [SdfW-1:0] sdf_d;
  logic [SdfW-1:0] sdf_q;
  flags_t          flgo_q;

  assign scaled = prod_q >> FRAC_BITS;
  assign sdf_d  = negm_q ? SdfW'(-scaled) : SdfW'(scaled);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vout_q <= 1'b0;
    end else if (en) begin
      vout_q <= vm_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sdf_q  <= sdf_d;
      flgo_q <= flgm_q;
    end
  end

  assign m_axis_tvalid = vout_q;
  assign m_axis_tdata  = OutW'({flgo_q.within_interior, flgo_q.within_bounds, sdf_q});

endmodule
